/* rtl/core/hei_pkg.sv */
// ----------------------------------------------------------------------------
// hei_pkg: shared types and codes for the hyphenation exception insert unit
// Request and result structs, token and status codes, and the job record
// that the front end hands to the insert engine.
// ----------------------------------------------------------------------------
`default_nettype none
package hei_pkg;

    localparam int KEY_DEPTH = 64;   // key buffer bytes (letters plus language)
    localparam int KEY_AW    = 6;
    localparam int LEN_W     = 7;    // key length, 0..64
    localparam int MASK_W    = 63;

    localparam logic [1:0] OP_LETTER   = 2'd0;
    localparam logic [1:0] OP_HYPHEN   = 2'd1;
    localparam logic [1:0] OP_WORD_END = 2'd2;
    localparam logic [1:0] OP_IMPROPER = 2'd3;

    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_NOT_LETTER = 3'd1;
    localparam logic [2:0] ST_IMPROPER   = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd3;
    localparam logic [2:0] ST_INSERTED   = 3'd4;
    localparam logic [2:0] ST_OVERFLOW   = 3'd5;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] letter_code;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [8:0] final_slot;
        logic [8:0] entry_count;
    } res_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [MASK_W-1:0] mask;
    } job_t;

    // key buffer access from the insert engine
    typedef struct packed {
        logic              we;
        logic [KEY_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [KEY_AW-1:0] raddr;
    } key_port_t;

endpackage
`default_nettype wire

/* rtl/core/hei_ram.sv */
// ----------------------------------------------------------------------------
// hei_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module hei_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/hei_queue.sv */
// ----------------------------------------------------------------------------
// hei_queue: two-entry job queue
// Carries word jobs from the front end to the insert engine.
// ----------------------------------------------------------------------------
`default_nettype none
module hei_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire hei_pkg::job_t push_job,
    input  wire logic          pop,
    output logic               not_empty,
    output hei_pkg::job_t      head
);

    hei_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign not_empty = (fill_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/hei_front.sv */
// ----------------------------------------------------------------------------
// hei_front: token front end
// Builds the word in the key buffer, keeps the hyphen mask, answers simple
// tokens and hands finished words to the insert engine.
// ----------------------------------------------------------------------------
`default_nettype none
module hei_front #(
    parameter int TABLE_SIZE  = 307,
    parameter int MAX_LETTERS = 63
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             accept,
    input  wire hei_pkg::req_t                    req,
    input  wire logic                             cfg_we,
    input  wire logic [7:0]                       cfg_wdata,
    input  wire logic [$clog2(TABLE_SIZE+1)-1:0]  count,
    input  wire logic                             job_done,
    input  wire hei_pkg::key_port_t               key_port,
    output logic [7:0]                            key_rdata,
    output logic                                  push,
    output hei_pkg::job_t                         push_job,
    output logic                                  pending,
    output logic                                  res_valid,
    output hei_pkg::res_t                         res
);

    localparam int CW = $clog2(TABLE_SIZE + 1);

    logic [7:0]                  language_reg;
    logic [hei_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [hei_pkg::MASK_W-1:0]  mask_reg, mask_next;
    logic                        pending_reg, pending_next;
    logic                        res_valid_reg, res_valid_next;
    logic [2:0]                  status_reg, status_next;
    logic [CW-1:0]               count_reg;
    logic                        fr_we;
    logic [7:0]                  fr_wdata;
    logic                        room;
    logic [31:0]                 count32;

    assign room = (len_reg < hei_pkg::LEN_W'(MAX_LETTERS));

    always_comb
    begin
        len_next       = len_reg;
        mask_next      = mask_reg;
        pending_next   = pending_reg & ~job_done;
        res_valid_next = 1'b0;
        status_next    = hei_pkg::ST_ACCEPTED;
        fr_we          = 1'b0;
        fr_wdata       = req.letter_code;
        push           = 1'b0;
        if (accept)
        begin
            res_valid_next = 1'b1;
            case (req.op)
                hei_pkg::OP_LETTER:
                begin
                    if (req.letter_code == 8'd0)
                    begin
                        status_next = hei_pkg::ST_NOT_LETTER;
                    end
                    else if (room)
                    begin
                        fr_we    = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                end
                hei_pkg::OP_HYPHEN:
                begin
                    if (room)
                    begin
                        mask_next = mask_reg | (hei_pkg::MASK_W'(1) << len_reg[hei_pkg::KEY_AW-1:0]);
                    end
                end
                hei_pkg::OP_IMPROPER:
                begin
                    status_next = hei_pkg::ST_IMPROPER;
                end
                default:
                begin
                    len_next  = '0;
                    mask_next = '0;
                    if (len_reg <= hei_pkg::LEN_W'(1))
                    begin
                        status_next = hei_pkg::ST_TOO_SHORT;
                    end
                    else if (count >= CW'(TABLE_SIZE))
                    begin
                        status_next = hei_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        // language byte closes the key; engine answers later
                        fr_we          = 1'b1;
                        fr_wdata       = language_reg;
                        push           = 1'b1;
                        pending_next   = 1'b1;
                        res_valid_next = 1'b0;
                    end
                end
            endcase
        end
    end

    assign push_job.len  = len_reg + 1'b1;
    assign push_job.mask = mask_reg;

    hei_ram #(
        .WIDTH (8),
        .DEPTH (hei_pkg::KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (pending_reg ? key_port.we : fr_we),
        .waddr (pending_reg ? key_port.waddr : len_reg[hei_pkg::KEY_AW-1:0]),
        .wdata (pending_reg ? key_port.wdata : fr_wdata),
        .raddr (key_port.raddr),
        .rdata (key_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            language_reg  <= 8'd0;
            len_reg       <= '0;
            mask_reg      <= '0;
            pending_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                language_reg <= cfg_wdata;
            end
            len_reg       <= len_next;
            mask_reg      <= mask_next;
            pending_reg   <= pending_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        count_reg  <= count;
    end

    assign count32         = 32'(count_reg);
    assign pending         = pending_reg;
    assign res_valid       = res_valid_reg;
    assign res.status      = status_reg;
    assign res.final_slot  = 9'd0;
    assign res.entry_count = count32[8:0];

endmodule
`default_nettype wire

/* rtl/core/hei_back.sv */
// ----------------------------------------------------------------------------
// hei_back: ordered hash table insert engine
// Clears the slot lengths after reset, hashes each queued key and walks the
// probe sequence, swapping entries byte by byte to keep the table ordered.
// ----------------------------------------------------------------------------
`default_nettype none
module hei_back #(
    parameter int TABLE_SIZE = 307
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            job_valid,
    input  wire hei_pkg::job_t                   job,
    output logic                                 pop,
    output hei_pkg::key_port_t                   key_port,
    input  wire logic [7:0]                      key_rdata,
    output logic                                 clearing,
    output logic [$clog2(TABLE_SIZE+1)-1:0]      count,
    output logic                                 res_valid,
    output hei_pkg::res_t                        res
);

    localparam int SLOTS = TABLE_SIZE + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(TABLE_SIZE + 1);
    localparam int HW    = $clog2(2 * TABLE_SIZE + 256);
    localparam int TAW   = $clog2(SLOTS * hei_pkg::KEY_DEPTH);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_H_RD  = 4'd2;
    localparam logic [3:0] S_H_ADD = 4'd3;
    localparam logic [3:0] S_H_MOD = 4'd4;
    localparam logic [3:0] S_P_RD  = 4'd5;
    localparam logic [3:0] S_P_CHK = 4'd6;
    localparam logic [3:0] S_C_RD  = 4'd7;
    localparam logic [3:0] S_C_CMP = 4'd8;
    localparam logic [3:0] S_S_RD  = 4'd9;
    localparam logic [3:0] S_S_WR  = 4'd10;
    localparam logic [3:0] S_S_FIN = 4'd11;
    localparam logic [3:0] S_NEXT  = 4'd12;
    localparam logic [3:0] S_W_RD  = 4'd13;
    localparam logic [3:0] S_W_WR  = 4'd14;
    localparam logic [3:0] S_W_FIN = 4'd15;

    logic [3:0]                 state_reg, state_next;
    logic [SW-1:0]              clr_reg, clr_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [SW-1:0]              h_reg, h_next;
    logic [HW-1:0]              x_reg, x_next;
    logic [hei_pkg::LEN_W-1:0]  i_reg, i_next;
    logic [hei_pkg::LEN_W-1:0]  clen_reg, clen_next;
    logic [hei_pkg::MASK_W-1:0] cpos_reg, cpos_next;
    logic [hei_pkg::LEN_W-1:0]  sl_reg, sl_next;
    logic [hei_pkg::MASK_W-1:0] spos_reg, spos_next;
    logic [hei_pkg::LEN_W-1:0]  span_reg, span_next;
    logic                       res_valid_reg, res_valid_next;
    logic [SW-1:0]              slot_reg, slot_next;

    logic                       len_we;
    logic [SW-1:0]              len_waddr;
    logic [hei_pkg::LEN_W-1:0]  len_wdata, len_rdata;
    logic                       pos_we;
    logic [hei_pkg::MASK_W-1:0] pos_rdata;
    logic                       tab_we;
    logic [7:0]                 tab_rdata;
    logic [TAW-1:0]             tab_addr;
    logic [31:0]                slot32, count32;

    assign tab_addr = TAW'({h_reg, i_reg[hei_pkg::KEY_AW-1:0]});

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        h_next         = h_reg;
        x_next         = x_reg;
        i_next         = i_reg;
        clen_next      = clen_reg;
        cpos_next      = cpos_reg;
        sl_next        = sl_reg;
        spos_next      = spos_reg;
        span_next      = span_reg;
        slot_next      = slot_reg;
        res_valid_next = 1'b0;
        pop            = 1'b0;
        len_we         = 1'b0;
        len_waddr      = h_reg;
        len_wdata      = clen_reg;
        pos_we         = 1'b0;
        tab_we         = 1'b0;
        key_port.we    = 1'b0;
        key_port.waddr = i_reg[hei_pkg::KEY_AW-1:0];
        key_port.wdata = tab_rdata;
        key_port.raddr = i_reg[hei_pkg::KEY_AW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                len_we    = 1'b1;
                len_waddr = clr_reg;
                len_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == SW'(TABLE_SIZE))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (job_valid)
                begin
                    pop        = 1'b1;
                    clen_next  = job.len;
                    cpos_next  = job.mask;
                    h_next     = '0;
                    i_next     = '0;
                    count_next = count_reg + 1'b1;
                    state_next = S_H_RD;
                end
            end
            S_H_RD:
            begin
                state_next = S_H_ADD;
            end
            S_H_ADD:
            begin
                x_next     = HW'({h_reg, 1'b0}) + HW'(key_rdata);
                state_next = S_H_MOD;
            end
            S_H_MOD:
            begin
                if (x_reg >= HW'(TABLE_SIZE))
                begin
                    x_next = x_reg - HW'(TABLE_SIZE);
                end
                else
                begin
                    h_next = x_reg[SW-1:0];
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 == clen_reg)
                    begin
                        state_next = S_P_RD;
                    end
                    else
                    begin
                        state_next = S_H_RD;
                    end
                end
            end
            S_P_RD:
            begin
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                sl_next   = len_rdata;
                spos_next = pos_rdata;
                span_next = (len_rdata > clen_reg) ? len_rdata : clen_reg;
                i_next    = '0;
                if (len_rdata == '0)
                begin
                    state_next = S_W_RD;
                end
                else if (len_rdata < clen_reg)
                begin
                    state_next = S_S_RD;
                end
                else if (len_rdata > clen_reg)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_C_RD;
                end
            end
            S_C_RD:
            begin
                state_next = S_C_CMP;
            end
            S_C_CMP:
            begin
                if (tab_rdata < key_rdata)
                begin
                    i_next     = '0;
                    state_next = S_S_RD;
                end
                else if (tab_rdata > key_rdata)
                begin
                    state_next = S_NEXT;
                end
                else if (i_reg + 1'b1 == sl_reg)
                begin
                    // equal keys swap as well
                    i_next     = '0;
                    state_next = S_S_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_C_RD;
                end
            end
            S_S_RD:
            begin
                state_next = S_S_WR;
            end
            S_S_WR:
            begin
                tab_we      = 1'b1;
                key_port.we = 1'b1;
                i_next      = i_reg + 1'b1;
                if (i_reg + 1'b1 == span_reg)
                begin
                    state_next = S_S_FIN;
                end
                else
                begin
                    state_next = S_S_RD;
                end
            end
            S_S_FIN:
            begin
                len_we     = 1'b1;
                pos_we     = 1'b1;
                clen_next  = sl_reg;
                cpos_next  = spos_reg;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                h_next     = (h_reg == '0) ? SW'(TABLE_SIZE) : h_reg - 1'b1;
                state_next = S_P_RD;
            end
            S_W_RD:
            begin
                state_next = S_W_WR;
            end
            S_W_WR:
            begin
                tab_we = 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 == clen_reg)
                begin
                    state_next = S_W_FIN;
                end
                else
                begin
                    state_next = S_W_RD;
                end
            end
            default:
            begin
                len_we         = 1'b1;
                pos_we         = 1'b1;
                slot_next      = h_reg;
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
        endcase
    end

    hei_ram #(
        .WIDTH (hei_pkg::LEN_W),
        .DEPTH (SLOTS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (h_reg),
        .rdata (len_rdata)
    );

    hei_ram #(
        .WIDTH (hei_pkg::MASK_W),
        .DEPTH (SLOTS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (h_reg),
        .wdata (cpos_reg),
        .raddr (h_reg),
        .rdata (pos_rdata)
    );

    hei_ram #(
        .WIDTH (8),
        .DEPTH (SLOTS * hei_pkg::KEY_DEPTH)
    ) u_tab_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_addr),
        .wdata (key_rdata),
        .raddr (tab_addr),
        .rdata (tab_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        x_reg    <= x_next;
        i_reg    <= i_next;
        clen_reg <= clen_next;
        cpos_reg <= cpos_next;
        sl_reg   <= sl_next;
        spos_reg <= spos_next;
        span_reg <= span_next;
        slot_reg <= slot_next;
    end

    assign slot32          = 32'(slot_reg);
    assign count32         = 32'(count_reg);
    assign clearing        = (state_reg == S_CLEAR);
    assign count           = count_reg;
    assign res_valid       = res_valid_reg;
    assign res.status      = hei_pkg::ST_INSERTED;
    assign res.final_slot  = slot32[8:0];
    assign res.entry_count = count32[8:0];

endmodule
`default_nettype wire

/* rtl/core/hyphenation_exception_insert_unit.sv */
// Letter, hyphen, improper and rejected word-end requests answer in the cycle after they are accepted.
// An inserted word hashes its key byte by byte, with a modulo subtract step as needed per byte;
// then each probed slot is read and checked, its key compared byte by byte and, if needed, swapped byte by byte;
// writing the final slot goes byte by byte as well. The table RAM is byte-serial.
// Throughput: no request is taken while an insert runs (busy high); otherwise one per cycle.
// Reset: asynchronous, active low; afterwards busy stays high while the slot-length RAM is
// cleared. The result strobe cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// hyphenation_exception_insert_unit: hyphenation exception inserter
// Front end builds words from tokens; a job queue feeds the ordered hash
// table insert engine. Results come from whichever side finished.
// ----------------------------------------------------------------------------
`default_nettype none
module hyphenation_exception_insert_unit #(
    parameter int TABLE_SIZE  = 307,
    parameter int MAX_LETTERS = 63
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire hei_pkg::req_t req,
    output logic               done,
    output hei_pkg::res_t      result,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_wdata
);

    localparam int CW = $clog2(TABLE_SIZE + 1);

    logic               accept;
    logic               clearing;
    logic               pending;
    logic               push;
    logic               pop;
    logic               job_valid;
    hei_pkg::job_t      push_job;
    hei_pkg::job_t      head_job;
    hei_pkg::key_port_t key_port;
    logic [7:0]         key_rdata;
    logic [CW-1:0]      count;
    logic               fr_valid;
    logic               bk_valid;
    hei_pkg::res_t      fr_res;
    hei_pkg::res_t      bk_res;

    // one request in flight per insert; the front end holds pending until
    // the engine reports the slot
    assign busy   = clearing | pending;
    assign accept = start & ~busy;

    hei_front #(
        .TABLE_SIZE  (TABLE_SIZE),
        .MAX_LETTERS (MAX_LETTERS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .count     (count),
        .job_done  (bk_valid),
        .key_port  (key_port),
        .key_rdata (key_rdata),
        .push      (push),
        .push_job  (push_job),
        .pending   (pending),
        .res_valid (fr_valid),
        .res       (fr_res)
    );

    hei_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .not_empty (job_valid),
        .head      (head_job)
    );

    hei_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (head_job),
        .pop       (pop),
        .key_port  (key_port),
        .key_rdata (key_rdata),
        .clearing  (clearing),
        .count     (count),
        .res_valid (bk_valid),
        .res       (bk_res)
    );

    // at most one side reports in a cycle
    assign done   = fr_valid | bk_valid;
    assign result = bk_valid ? bk_res : fr_res;

`ifndef SYNTHESIS
    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(fr_valid && bk_valid))
        else $error("front and engine results collide");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(TABLE_SIZE))
        else $error("entry count beyond table size");

    a_front_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        fr_valid |-> $past(accept))
        else $error("front result without request");

    a_insert_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        bk_valid |-> pending)
        else $error("insert result with nothing pending");
`endif

endmodule
`default_nettype wire
